### rtl/core/lcgdh_pkg.sv
package lcgdh_pkg;

    localparam int VALUE_W     = 31;
    localparam int BIN_W       = 4;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int PRODUCT_W   = 2 * VALUE_W;
    localparam int DIVIDEND_W  = PRODUCT_W + 1;
    localparam int SCALED_W    = VALUE_W + BIN_W;
    localparam int STEP_CNT_W  = 6;

    localparam logic [VALUE_W-1:0] MULTIPLIER_RESET = VALUE_W'(16807);
    localparam logic [VALUE_W-1:0] INCREMENT_RESET  = '0;
    localparam logic [VALUE_W-1:0] MODULUS_RESET    = VALUE_W'(2147483647);
    localparam logic [VALUE_W-1:0] STATE_SEED       = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] MODULUS_MIN      = VALUE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_INCREMENT  = 2'd1,
        REG_MODULUS    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             inc;
        logic [BIN_W-1:0] bin;
    } hist_ctrl_t;

endpackage

### rtl/core/lcgdh_step_if.sv
interface lcgdh_step_if;
    logic valid;
    logic ready;
    logic step_request;

    modport source (output valid, output step_request, input ready);
    modport sink (input valid, input step_request, output ready);
endinterface

### rtl/core/lcgdh_result_if.sv
interface lcgdh_result_if;
    logic                          valid;
    logic                          ready;
    logic [lcgdh_pkg::VALUE_W-1:0] value;
    logic [lcgdh_pkg::BIN_W-1:0]   bin_index;
    logic [lcgdh_pkg::COUNT_W-1:0] bin_count;

    modport source (output valid, output value, output bin_index, output bin_count,
                    input ready);
    modport sink (input valid, input value, input bin_index, input bin_count,
                  output ready);
endinterface

### rtl/core/lcgdh_cfg_if.sv
interface lcgdh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcgdh_pkg::CFG_IDX_W-1:0] index;
    logic [lcgdh_pkg::VALUE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/lcgdh_divstep.sv
module lcgdh_divstep (
    input  logic [lcgdh_pkg::VALUE_W-1:0] rem,
    input  logic                          bit_in,
    input  logic [lcgdh_pkg::VALUE_W-1:0] modulus,
    output logic [lcgdh_pkg::VALUE_W-1:0] rem_next,
    output logic                          q_bit
);

    logic [lcgdh_pkg::VALUE_W:0] shifted;
    logic [lcgdh_pkg::VALUE_W:0] diff;

    always_comb
    begin
        shifted  = {rem, bit_in};
        diff     = shifted - {1'b0, modulus};
        q_bit    = (shifted >= {1'b0, modulus});
        rem_next = q_bit ? diff[lcgdh_pkg::VALUE_W-1:0]
                         : shifted[lcgdh_pkg::VALUE_W-1:0];
    end

endmodule

### rtl/core/lcgdh_hist.sv
module lcgdh_hist #(
    parameter int NUM_BINS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcgdh_pkg::hist_ctrl_t         ctrl,
    output logic [lcgdh_pkg::COUNT_W-1:0] count
);

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [lcgdh_pkg::COUNT_W-1:0] counters_reg [NUM_BINS];
    logic [lcgdh_pkg::COUNT_W-1:0] count_reg;
    logic [lcgdh_pkg::COUNT_W-1:0] current;
    logic [lcgdh_pkg::COUNT_W-1:0] updated;
    logic [IDX_W-1:0]              idx;

    always_comb
    begin
        idx     = ctrl.bin[IDX_W-1:0];
        current = counters_reg[idx];
        updated = (&current) ? current : current + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                counters_reg[k] <= '0;
            end
            count_reg <= '0;
        end
        else if (ctrl.inc)
        begin
            counters_reg[idx] <= updated;
            count_reg         <= updated;
        end
    end

    assign count = count_reg;

endmodule

### rtl/core/lcg_with_decile_histogram.sv
// Each request with step_request set produces one result: a multiply step, an add step,
// the modulo on the shared compare-subtract unit, a scaling step, the bin on the same
// unit and a count update.
// The next request is taken once the result has been accepted downstream, so no new
// request is accepted while an earlier one is still in progress.
// Reset seeds the generator with one, clears all bin counters and loads register defaults.
module lcg_with_decile_histogram #(
    parameter int NUM_BINS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lcgdh_cfg_if.sink             cfg,
    lcgdh_step_if.sink            step,
    lcgdh_result_if.source        result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MOD,
        ST_SCALE,
        ST_BIN,
        ST_COUNT,
        ST_OUT
    } state_t;

    localparam int VW = lcgdh_pkg::VALUE_W;
    localparam int DW = lcgdh_pkg::DIVIDEND_W;
    localparam int BW = lcgdh_pkg::BIN_W;
    localparam int SW = lcgdh_pkg::SCALED_W;
    localparam int CW = lcgdh_pkg::STEP_CNT_W;

    state_t                         state_reg, state_next;
    logic [VW-1:0]                  multiplier_reg, increment_reg, modulus_reg;
    logic [VW-1:0]                  gen_reg, gen_next;
    logic [lcgdh_pkg::PRODUCT_W-1:0] product_reg, product_next;
    logic [DW-1:0]                  dividend_reg, dividend_next;
    logic [VW-1:0]                  rem_reg, rem_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [BW-1:0]                  bin_reg, bin_next;
    logic                           valid_reg, valid_next;

    logic [VW-1:0]                  mod_eff;
    logic [VW-1:0]                  unit_rem;
    logic                           unit_q;
    logic [SW-1:0]                  scaled;
    lcgdh_pkg::hist_ctrl_t          hist_ctrl;
    logic [lcgdh_pkg::COUNT_W-1:0]  hist_count;

    assign mod_eff = (modulus_reg < lcgdh_pkg::MODULUS_MIN) ? lcgdh_pkg::MODULUS_MIN
                                                            : modulus_reg;

    lcgdh_divstep u_divstep (
        .rem      (rem_reg),
        .bit_in   (dividend_reg[DW-1]),
        .modulus  (mod_eff),
        .rem_next (unit_rem),
        .q_bit    (unit_q)
    );

    lcgdh_hist #(
        .NUM_BINS (NUM_BINS)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hist_ctrl),
        .count (hist_count)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= lcgdh_pkg::MULTIPLIER_RESET;
            increment_reg  <= lcgdh_pkg::INCREMENT_RESET;
            modulus_reg    <= lcgdh_pkg::MODULUS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lcgdh_pkg::REG_MULTIPLIER: multiplier_reg <= cfg.data;
                lcgdh_pkg::REG_INCREMENT:  increment_reg  <= cfg.data;
                lcgdh_pkg::REG_MODULUS:    modulus_reg    <= cfg.data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        scaled        = SW'(gen_reg) * SW'(NUM_BINS);
        state_next    = state_reg;
        gen_next      = gen_reg;
        product_next  = product_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        bin_next      = bin_reg;
        valid_next    = valid_reg;
        hist_ctrl.inc = 1'b0;
        hist_ctrl.bin = bin_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (step.valid && step.step_request)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                product_next = multiplier_reg * gen_reg;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                dividend_next = DW'(product_reg) + DW'(increment_reg);
                rem_next      = '0;
                cnt_next      = CW'(DW - 1);
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                rem_next      = unit_rem;
                dividend_next = dividend_reg << 1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    gen_next   = unit_rem;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                rem_next      = scaled[SW-1:BW];
                dividend_next = {scaled[BW-1:0], {(DW - BW){1'b0}}};
                cnt_next      = CW'(BW - 1);
                bin_next      = '0;
                state_next    = ST_BIN;
            end
            ST_BIN:
            begin
                rem_next      = unit_rem;
                dividend_next = dividend_reg << 1;
                bin_next      = {bin_reg[BW-2:0], unit_q};
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                hist_ctrl.inc = 1'b1;
                valid_next    = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gen_reg   <= lcgdh_pkg::STATE_SEED;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg  <= product_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        bin_reg      <= bin_next;
    end

    assign step.ready       = (state_reg == ST_IDLE);
    assign result.valid     = valid_reg;
    assign result.value     = gen_reg;
    assign result.bin_index = bin_reg;
    assign result.bin_count = hist_count;

endmodule

### tb/sv/lcg_with_decile_histogram_test.sv
`timescale 1ns / 100ps

module lcg_with_decile_histogram_test;

    localparam int VALUE_W   = lcgdh_pkg::VALUE_W;
    localparam int BIN_W     = lcgdh_pkg::BIN_W;
    localparam int COUNT_W   = lcgdh_pkg::COUNT_W;
    localparam int CFG_IDX_W = lcgdh_pkg::CFG_IDX_W;

    localparam int NUM_BINS      = 10;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int STALL_CYCLES  = 300;

    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;
    localparam logic [VALUE_W-1:0]   FIELD_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_count;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n;

    lcgdh_cfg_if    cfg_bus();
    lcgdh_step_if   step_bus();
    lcgdh_result_if result_bus();

    lcg_with_decile_histogram #(
        .NUM_BINS(NUM_BINS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .step(step_bus),
        .result(result_bus)
    );

    logic [VALUE_W-1:0] reg_mult = lcgdh_pkg::MULTIPLIER_RESET;
    logic [VALUE_W-1:0] reg_inc  = lcgdh_pkg::INCREMENT_RESET;
    logic [VALUE_W-1:0] reg_mod  = lcgdh_pkg::MODULUS_RESET;
    logic [VALUE_W-1:0] gen_state = lcgdh_pkg::STATE_SEED;
    logic [COUNT_W-1:0] bin_tally [NUM_BINS] = '{default: '0};

    draw_t pending_draws[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    hold_left = 0;
    bit    idle_on = 1'b1;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic draw_t lcg_advance();
        longint unsigned span;
        longint unsigned next_val;
        longint unsigned scaled;
        draw_t d;
        span = (reg_mod < lcgdh_pkg::MODULUS_MIN) ? 64'(lcgdh_pkg::MODULUS_MIN)
                                                  : 64'(reg_mod);
        next_val = (64'(reg_mult) * 64'(gen_state) + 64'(reg_inc)) % span;
        scaled = (next_val * 64'(NUM_BINS)) / span;
        if (scaled >= 64'(NUM_BINS))
        begin
            scaled = 64'(NUM_BINS - 1);
        end
        gen_state = next_val[VALUE_W-1:0];
        if (bin_tally[scaled] != '1)
        begin
            bin_tally[scaled] = bin_tally[scaled] + 1'b1;
        end
        d.value = next_val[VALUE_W-1:0];
        d.bin_index = scaled[BIN_W-1:0];
        d.bin_count = bin_tally[scaled];
        return d;
    endfunction

    task automatic send_step(input bit req);
        while (idle_on && $urandom_range(99) < 6)
        begin
            step_bus.valid <= 1'b0;
            @(posedge clk);
        end
        step_bus.valid <= 1'b1;
        step_bus.step_request <= req;
        do @(posedge clk); while (!step_bus.ready);
        if (req)
        begin
            pending_draws.push_back(lcg_advance());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data,
                             input bit last);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == lcgdh_pkg::REG_MULTIPLIER)
        begin
            reg_mult = data;
        end
        else if (idx == lcgdh_pkg::REG_INCREMENT)
        begin
            reg_inc = data;
        end
        else if (idx == lcgdh_pkg::REG_MODULUS)
        begin
            reg_mod = data;
        end
        if (last)
        begin
            cfg_bus.valid <= 1'b0;
        end
    endtask

    task automatic apply_settings(input logic [VALUE_W-1:0] mult, input logic [VALUE_W-1:0] inc,
                                  input logic [VALUE_W-1:0] span);
        write_reg(lcgdh_pkg::REG_MULTIPLIER, mult, 1'b0);
        write_reg(lcgdh_pkg::REG_INCREMENT, inc, 1'b0);
        write_reg(lcgdh_pkg::REG_MODULUS, span, 1'b1);
    endtask

    task automatic drain_results();
        step_bus.valid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_modulus();
        case ($urandom_range(4))
            0: return VALUE_W'($urandom_range(20));
            1: return FIELD_MAX;
            2: return VALUE_W'($urandom_range(1000, 2));
            3: return VALUE_W'($urandom) | VALUE_W'(1 << 30);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return FIELD_MAX;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic test_seeded_sequence();
        repeat (3) send_step(1'b1);
        drain_results();
    endtask

    task automatic test_ignored_ticks();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        drain_results();
        write_reg(REG_NONE, FIELD_MAX, 1'b0);
        write_reg(REG_NONE, VALUE_W'($urandom), 1'b1);
        send_step(1'b1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        apply_settings('0, FIELD_MAX, FIELD_MAX);
        send_step(1'b1);
        drain_results();
        apply_settings(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        repeat (2) send_step(1'b1);
        drain_results();
        apply_settings(FIELD_MAX, '0, '0);
        repeat (2) send_step(1'b1);
        drain_results();
        apply_settings(VALUE_W'(1), VALUE_W'(1), VALUE_W'(1));
        repeat (2) send_step(1'b1);
        drain_results();
        apply_settings(VALUE_W'(3), VALUE_W'(1), VALUE_W'(2));
        repeat (2) send_step(1'b1);
        drain_results();
    endtask

    task automatic test_modulus_shrink();
        apply_settings(lcgdh_pkg::MULTIPLIER_RESET, lcgdh_pkg::INCREMENT_RESET,
                       lcgdh_pkg::MODULUS_RESET);
        repeat (2) send_step(1'b1);
        drain_results();
        write_reg(lcgdh_pkg::REG_MODULUS, VALUE_W'(7), 1'b1);
        repeat (2) send_step(1'b1);
        drain_results();
    endtask

    task automatic test_output_stall();
        apply_settings(VALUE_W'($urandom), VALUE_W'($urandom), random_modulus());
        hold_left = STALL_CYCLES;
        repeat (6) send_step(1'b1);
        drain_results();
    endtask

    task automatic test_random_phases();
        int accepted;
        bit req;
        for (int phase = 0; phase < 9; phase++)
        begin
            idle_on = (phase != 4);
            if ($urandom_range(2) == 0)
            begin
                write_reg(REG_NONE, VALUE_W'($urandom), 1'b0);
            end
            apply_settings(random_operand(), random_operand(), random_modulus());
            accepted = 0;
            while (accepted < 100)
            begin
                req = ($urandom_range(99) >= 5);
                send_step(req);
                if (req)
                begin
                    accepted++;
                end
            end
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(99) < 6)
            begin
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_draws
        draw_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d bin %0d count %0d",
                         $time, result_bus.value, result_bus.bin_index, result_bus.bin_count);
                error_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (result_bus.value !== want.value)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want.value, result_bus.value);
                    error_count++;
                end
                if (result_bus.bin_index !== want.bin_index)
                begin
                    $display("%0t: bin_index mismatch, expected %0d, actual %0d",
                             $time, want.bin_index, result_bus.bin_index);
                    error_count++;
                end
                if (result_bus.bin_count !== want.bin_count)
                begin
                    $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                             $time, want.bin_count, result_bus.bin_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= lcgdh_pkg::REG_MULTIPLIER;
        cfg_bus.data <= '0;
        step_bus.valid <= 1'b0;
        step_bus.step_request <= 1'b0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_seeded_sequence();
        test_ignored_ticks();
        test_register_extremes();
        test_modulus_shrink();
        test_output_stall();
        test_random_phases();

        drain_results();
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
